/* src/sprite_animation_sequencer_macros.svh */
`ifndef SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define SAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define SAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sas_pkg.sv */
package sas_pkg;

    localparam int IN_W      = 112;
    localparam int OUT_W     = 48;
    localparam int ENTRY_W   = 54;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [15:0] SPEED_RESET = 16'd4096;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_PLAY  = 2'd1,
        REQ_SPEED = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        RD_SEL    = 2'd0,
        RD_CUR    = 2'd1,
        RD_FOLLOW = 2'd2
    } rd_src_t;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] rate;
        logic        wrap;
        logic [4:0]  follow;
    } clip_entry_t;

    typedef struct packed {
        logic    load_req;
        logic    rd_en;
        rd_src_t rd_src;
        logic    add_commit;
        logic    speed_commit;
        logic    deact;
        logic    div_init;
        logic    div_step;
        logic    play_commit;
        logic    mul1;
        logic    mul2;
        logic    tsum;
        logic    tick_commit;
        logic    chain_commit;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic sel_present;
        logic tick_idle;
        logic div_last;
        logic chain;
        logic follow_present;
        logic out_free;
    } dp_status_t;

endpackage

/* src/sas_ram.sv */
module sas_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sas_ctrl.sv */
`include "sprite_animation_sequencer_macros.svh"

module sas_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sas_pkg::dp_status_t status,
    output sas_pkg::dp_cmd_t   cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECODE = 11'b000_0000_0010,
        S_PWAIT  = 11'b000_0000_0100,
        S_DIV    = 11'b000_0000_1000,
        S_PFIN   = 11'b000_0001_0000,
        S_TWAIT  = 11'b000_0010_0000,
        S_MUL2   = 11'b000_0100_0000,
        S_TSUM   = 11'b000_1000_0000,
        S_TADD   = 11'b001_0000_0000,
        S_CWAIT  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = sas_pkg::RD_SEL;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (status.req)
                    sas_pkg::REQ_ADD: begin
                        cmd.add_commit = 1'b1;
                        state_next     = S_OUT;
                    end
                    sas_pkg::REQ_SPEED: begin
                        cmd.speed_commit = 1'b1;
                        state_next       = S_OUT;
                    end
                    sas_pkg::REQ_PLAY: begin
                        if (status.sel_present) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = sas_pkg::RD_SEL;
                            state_next = S_PWAIT;
                        end else begin
                            cmd.deact  = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                    sas_pkg::REQ_TICK: begin
                        if (status.tick_idle) begin
                            state_next = S_OUT;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = sas_pkg::RD_CUR;
                            state_next = S_TWAIT;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_PWAIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = S_PFIN;
                end
            end
            S_PFIN: begin
                cmd.play_commit = 1'b1;
                state_next      = S_OUT;
            end
            S_TWAIT: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_TSUM;
            end
            S_TSUM: begin
                cmd.tsum   = 1'b1;
                state_next = S_TADD;
            end
            S_TADD: begin
                if (!status.chain) begin
                    cmd.tick_commit = 1'b1;
                    state_next      = S_OUT;
                end else if (status.follow_present) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = sas_pkg::RD_FOLLOW;
                    state_next = S_CWAIT;
                end else begin
                    cmd.deact  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_CWAIT: begin
                cmd.chain_commit = 1'b1;
                state_next       = S_OUT;
            end
            S_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    `SAS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")
    `SAS_ASSERT_IMPL(a_div_in_play, cmd.div_step, status.req == sas_pkg::REQ_PLAY,
        "divider stepped outside a play request")

endmodule

/* src/sas_dpath.sv */
`include "sprite_animation_sequencer_macros.svh"

module sas_dpath #(
    parameter int MAX_CLIPS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [1:0]                 s_tuser,
    input  logic [sas_pkg::IN_W-1:0]   s_tdata,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [sas_pkg::OUT_W-1:0]  m_tdata,
    input  sas_pkg::dp_cmd_t           cmd,
    output sas_pkg::dp_status_t        status
);

    localparam int AW = $clog2(MAX_CLIPS);
    localparam int CW = $clog2(MAX_CLIPS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CLIPS);
    localparam logic [sas_pkg::DIV_CNT_W-1:0] DIV_CNT_INIT =
        sas_pkg::DIV_CNT_W'(sas_pkg::DIV_STEPS - 1);

    // request fields
    sas_pkg::req_t req_reg;
    logic [15:0] start_reg, end_reg, fps_reg, offset_reg, speed_in_reg, elapsed_reg;
    logic        looping_reg;
    logic [4:0]  next_reg;
    logic [3:0]  sel_reg;

    // block state
    logic [CW-1:0] count_reg, count_next;
    logic          active_reg, active_next;
    logic [3:0]    cur_reg, cur_next;
    logic [31:0]   pos_reg, pos_next;
    logic [15:0]   speed_reg, speed_next;
    logic          fin_reg, fin_next;

    // per-item work registers
    logic [3:0]  id_res_reg;
    logic        full_res_reg;
    logic [3:0]  chain_id_reg;
    logic [16:0] rem_reg, len_reg;
    logic [15:0] dvd_reg;
    logic [sas_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [31:0] p1_reg;
    logic [47:0] p2_reg;
    logic [32:0] sum_reg;

    logic                     m_tvalid_reg;
    logic [sas_pkg::OUT_W-1:0] m_tdata_reg;

    // RAM
    logic [sas_pkg::ENTRY_W-1:0] ram_rdata;
    sas_pkg::clip_entry_t wr_entry, entry;
    logic [3:0]  rd_id;
    logic [AW+3:0] rd_ext;
    logic        full;
    logic [CW+3:0] cnt_ext, sel_ext, fol_ext;
    logic [16:0] len;
    logic [16:0] trial;
    logic [16:0] psum;
    logic [16:0] last_p1;
    logic [32:0] limit, wrapped, tick_pos;
    logic        over;
    logic [31:0] tick_sat;

    assign wr_entry = '{first: start_reg, last: end_reg, rate: fps_reg,
                        wrap: looping_reg, follow: next_reg};
    assign entry = sas_pkg::clip_entry_t'(ram_rdata);

    always_comb begin
        case (cmd.rd_src)
            sas_pkg::RD_SEL:    rd_id = sel_reg;
            sas_pkg::RD_CUR:    rd_id = cur_reg;
            sas_pkg::RD_FOLLOW: rd_id = entry.follow[3:0];
            default:            rd_id = sel_reg;
        endcase
    end

    assign rd_ext = {{AW{1'b0}}, rd_id};
    assign full   = (count_reg == MAX_CNT);

    sas_ram #(
        .WIDTH (sas_pkg::ENTRY_W),
        .DEPTH (MAX_CLIPS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.add_commit && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (rd_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign cnt_ext = {4'b0, count_reg};
    assign sel_ext = {{CW{1'b0}}, sel_reg};
    assign fol_ext = {{CW{1'b0}}, entry.follow[3:0]};

    assign len   = (entry.last >= entry.first)
                 ? ({1'b0, entry.last} - {1'b0, entry.first} + 17'd1) : 17'd1;
    assign trial = {rem_reg[15:0], dvd_reg[15]};
    assign psum  = {1'b0, entry.first} + rem_reg;

    assign last_p1  = {1'b0, entry.last} + 17'd1;
    assign limit    = {last_p1, 16'h0000};
    assign over     = (sum_reg >= limit);
    assign wrapped  = sum_reg - {len, 16'h0000};
    assign tick_pos = (over && entry.wrap) ? wrapped : sum_reg;
    assign tick_sat = tick_pos[32] ? 32'hFFFF_FFFF : tick_pos[31:0];

    assign status.req            = req_reg;
    assign status.sel_present    = (sel_ext < cnt_ext);
    assign status.tick_idle      = fin_reg || !active_reg;
    assign status.div_last       = (div_cnt_reg == '0);
    assign status.chain          = over && !entry.wrap && !entry.follow[4];
    assign status.follow_present = (fol_ext < cnt_ext);
    assign status.out_free       = !m_tvalid_reg || m_tready;

    always_comb begin
        count_next  = count_reg;
        active_next = active_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        speed_next  = speed_reg;
        fin_next    = fin_reg;
        if (cmd.add_commit && !full) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.deact) begin
            active_next = 1'b0;
        end
        if (cmd.speed_commit) begin
            speed_next = speed_in_reg;
        end
        if (cmd.play_commit) begin
            active_next = 1'b1;
            cur_next    = sel_reg;
            fin_next    = 1'b0;
            pos_next    = {psum[15:0], 16'h0000};
            speed_next  = speed_in_reg;
        end
        if (cmd.tick_commit) begin
            pos_next = tick_sat;
            if (over && !entry.wrap) begin
                fin_next = 1'b1;
            end
        end
        if (cmd.chain_commit) begin
            active_next = 1'b1;
            cur_next    = chain_id_reg;
            fin_next    = 1'b0;
            pos_next    = {entry.first, 16'h0000};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            active_reg   <= 1'b0;
            cur_reg      <= '0;
            pos_reg      <= '0;
            speed_reg    <= sas_pkg::SPEED_RESET;
            fin_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            active_reg <= active_next;
            cur_reg    <= cur_next;
            pos_reg    <= pos_next;
            speed_reg  <= speed_next;
            fin_reg    <= fin_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg      <= sas_pkg::req_t'(s_tuser);
            start_reg    <= s_tdata[15:0];
            end_reg      <= s_tdata[31:16];
            fps_reg      <= s_tdata[47:32];
            looping_reg  <= s_tdata[48];
            next_reg     <= s_tdata[53:49];
            sel_reg      <= s_tdata[57:54];
            offset_reg   <= s_tdata[73:58];
            speed_in_reg <= s_tdata[89:74];
            elapsed_reg  <= s_tdata[105:90];
            id_res_reg   <= '0;
            full_res_reg <= 1'b0;
        end
        if (cmd.add_commit) begin
            full_res_reg <= full;
            id_res_reg   <= full ? 4'd0 : cnt_ext[3:0];
        end
        if (cmd.rd_en && cmd.rd_src == sas_pkg::RD_FOLLOW) begin
            chain_id_reg <= entry.follow[3:0];
        end
        if (cmd.div_init) begin
            rem_reg     <= '0;
            dvd_reg     <= offset_reg;
            len_reg     <= len;
            div_cnt_reg <= DIV_CNT_INIT;
        end else if (cmd.div_step) begin
            rem_reg     <= (trial >= len_reg) ? (trial - len_reg) : trial;
            dvd_reg     <= {dvd_reg[14:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - sas_pkg::DIV_CNT_W'(1);
        end
        if (cmd.mul1) begin
            p1_reg <= {16'd0, elapsed_reg} * {16'd0, entry.rate};
        end
        if (cmd.mul2) begin
            p2_reg <= {16'd0, p1_reg} * {32'd0, speed_reg};
        end
        if (cmd.tsum) begin
            sum_reg <= {1'b0, pos_reg} + {5'b0, p2_reg[47:20]};
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {5'b0, fin_reg, pos_reg, (active_reg ? cur_reg : 4'd0),
                            active_reg, full_res_reg, id_res_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SAS_ASSERT_IMPL(a_no_overwrite, cmd.out_load && m_tvalid_reg, m_tready,
        "result overwritten before transfer")
    `SAS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= MAX_CNT, "clip count past table size")

endmodule

/* src/sprite_animation_sequencer.sv */
// channel | dir | tdata (low bit up)                                     | tuser
// s_      | in  | start_frame, end_frame, frames_per_sec, looping,       | req_type
//         |     | next_clip, clip_sel, frame_offset, speed, elapsed      |
// m_      | out | assigned_id, table_full, clip_active, current_clip,    | -
//         |     | frame_pos, clip_done                                   |
// One item at a time; the next is taken once the result sits in the output register.
// Add and speed go from DECODE to OUT; a live tick reads the table, multiplies twice, sums and may chain.
// Play waits on the 16-step serial modulo (one quotient bit per cycle).
// Tick cost comes from the table read and two registered multiplies.
// Reset is synchronous; a stalled m_ side holds the result and blocks the next one.
module sprite_animation_sequencer #(
    parameter int MAX_CLIPS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // start_frame, end_frame, frames_per_sec, looping, next_clip, clip_sel,
    // frame_offset, speed, elapsed, zero fill
    input  logic [sas_pkg::IN_W-1:0]  s_tdata,
    // req_type
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // assigned_id, table_full, clip_active, current_clip, frame_pos, clip_done, zero fill
    output logic [sas_pkg::OUT_W-1:0] m_tdata
);

    sas_pkg::dp_cmd_t    cmd;
    sas_pkg::dp_status_t status;

    sas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sas_dpath #(
        .MAX_CLIPS (MAX_CLIPS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    typedef enum int {
        TRAFFIC_FREE,
        TRAFFIC_SRC_IDLE,
        TRAFFIC_SINK_STALL,
        TRAFFIC_BOTH
    } traffic_t;

    localparam int CLIP_SLOTS = 16;
    localparam int NO_NEXT = -1;
    localparam int SCRIPT_LEN = 23;
    localparam int ITEMS_PER_PHASE = 175;

    typedef struct {
        sas_pkg::req_t req;
        logic [15:0] start_frame;
        logic [15:0] end_frame;
        logic [15:0] frames_per_sec;
        logic        looping;
        logic [4:0]  next_clip;
        logic [3:0]  clip_sel;
        logic [15:0] frame_offset;
        logic [15:0] speed;
        logic [15:0] elapsed;
    } request_t;

    typedef struct {
        logic [3:0]  assigned_id;
        logic        table_full;
        logic        clip_active;
        logic [3:0]  current_clip;
        logic [31:0] frame_pos;
        logic        clip_done;
    } status_t;

    typedef struct {
        request_t rq;
        bit       typed;
        status_t  st;
    } script_row_t;

    typedef struct {
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] rate;
        logic        wrap;
        logic [4:0]  follow;
    } clip_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [sas_pkg::IN_W-1:0]  s_tdata = '0;
    logic [1:0]                s_tuser = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [sas_pkg::OUT_W-1:0] m_tdata;

    sprite_animation_sequencer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // animation state as seen by the bench
    clip_t       clips [CLIP_SLOTS];
    int unsigned clip_total = 0;
    bit          anim_on = 1'b0;
    logic [3:0]  anim_clip = '0;
    logic [31:0] anim_pos = '0;
    logic [15:0] anim_speed = sas_pkg::SPEED_RESET;
    bit          anim_done = 1'b0;

    status_t     pending_status [$];
    script_row_t script [SCRIPT_LEN];
    traffic_t    traffic = TRAFFIC_FREE;
    int          fails = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [16:0] clip_frames(input clip_t c);
        return (c.last >= c.first) ? ({1'b0, c.last} - {1'b0, c.first} + 17'd1) : 17'd1;
    endfunction

    function automatic bit enter_clip(input logic [3:0] id, input logic [15:0] offset);
        clip_t c;
        logic [16:0] len;
        if (id >= clip_total) begin
            anim_on = 1'b0;
            return 1'b0;
        end
        c = clips[id];
        len = clip_frames(c);
        anim_on = 1'b1;
        anim_clip = id;
        anim_done = 1'b0;
        anim_pos = ({16'd0, c.first} + ({16'd0, offset} % {15'd0, len})) << 16;
        return 1'b1;
    endfunction

    function automatic void advance_frames(input logic [15:0] elapsed);
        clip_t c;
        logic [63:0] delta;
        logic [63:0] pos;
        logic [63:0] limit;
        bit ok;
        if (anim_done || !anim_on)
            return;
        c = clips[anim_clip];
        delta = ({48'd0, elapsed} * {48'd0, c.rate} * {48'd0, anim_speed}) >> 20;
        pos = {32'd0, anim_pos} + delta;
        limit = ({48'd0, c.last} + 64'd1) << 16;
        if (pos >= limit) begin
            if (c.wrap) begin
                pos = pos - ({47'd0, clip_frames(c)} << 16);
            end else if (!c.follow[4]) begin
                ok = enter_clip(c.follow[3:0], 16'd0);
                return;
            end else begin
                anim_done = 1'b1;
            end
        end
        anim_pos = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
    endfunction

    function automatic status_t animate_step(input request_t rq);
        status_t st;
        st.assigned_id = '0;
        st.table_full = 1'b0;
        case (rq.req)
            sas_pkg::REQ_ADD: begin
                if (clip_total >= CLIP_SLOTS) begin
                    st.table_full = 1'b1;
                end else begin
                    clips[clip_total] = '{rq.start_frame, rq.end_frame, rq.frames_per_sec,
                                          rq.looping, rq.next_clip};
                    st.assigned_id = clip_total[3:0];
                    clip_total++;
                end
            end
            sas_pkg::REQ_PLAY: begin
                if (enter_clip(rq.clip_sel, rq.frame_offset))
                    anim_speed = rq.speed;
            end
            sas_pkg::REQ_SPEED: anim_speed = rq.speed;
            default: advance_frames(rq.elapsed);
        endcase
        st.clip_active = anim_on;
        st.current_clip = anim_on ? anim_clip : 4'd0;
        st.frame_pos = anim_pos;
        st.clip_done = anim_done;
        return st;
    endfunction

    function automatic request_t rq_of(input sas_pkg::req_t r, input int first,
                                       input int last, input int rate,
                                       input int wrap, input int nxt,
                                       input int sel, input int off,
                                       input int spd, input int el);
        request_t rq;
        rq = '{r, 16'(first), 16'(last), 16'(rate), 1'(wrap), 5'(nxt), 4'(sel),
               16'(off), 16'(spd), 16'(el)};
        return rq;
    endfunction

    function automatic status_t st_of(input logic [3:0] id, input logic full,
                                      input logic act, input logic [3:0] cur,
                                      input logic [31:0] pos, input logic done);
        status_t st;
        st = '{id, full, act, cur, pos, done};
        return st;
    endfunction

    function automatic logic [15:0] random_speed();
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom_range(16'h0800, 16'h3000));
        return 16'($urandom);
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int unsigned roll;
        logic [16:0] tail;
        rq.start_frame = 16'($urandom);
        rq.end_frame = 16'($urandom);
        rq.frames_per_sec = 16'($urandom);
        rq.looping = 1'($urandom);
        rq.next_clip = 5'($urandom);
        rq.clip_sel = 4'($urandom);
        rq.frame_offset = 16'($urandom);
        rq.speed = 16'($urandom);
        rq.elapsed = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < ((clip_total < CLIP_SLOTS) ? 12 : 4)) begin
            rq.req = sas_pkg::REQ_ADD;
            if ($urandom_range(0, 9) < 8) begin
                tail = {1'b0, rq.start_frame} + 17'($urandom_range(0, 15));
                rq.end_frame = tail[16] ? 16'hFFFF : tail[15:0];
            end
            if ($urandom_range(0, 3) != 0)
                rq.frames_per_sec = 16'($urandom_range(16'h0400, 16'h4000));
            roll = $urandom_range(0, 9);
            if (roll < 5)
                rq.next_clip = 5'(NO_NEXT);
            else if (roll < 9)
                rq.next_clip = 5'($urandom_range(0, 15));
        end else if (roll < 32) begin
            rq.req = sas_pkg::REQ_PLAY;
            if (clip_total > 0 && $urandom_range(0, 9) < 8)
                rq.clip_sel = 4'($urandom_range(0, clip_total - 1));
            rq.speed = random_speed();
        end else if (roll < 40) begin
            rq.req = sas_pkg::REQ_SPEED;
            rq.speed = random_speed();
        end else begin
            rq.req = sas_pkg::REQ_TICK;
            if ($urandom_range(0, 3) != 0)
                rq.elapsed = 16'($urandom_range(0, 16'h2000));
        end
        return rq;
    endfunction

    function automatic int src_idle_pct();
        case (traffic)
            TRAFFIC_SRC_IDLE: return 62;
            TRAFFIC_BOTH:     return 6;
            default:          return 0;
        endcase
    endfunction

    function automatic int sink_stall_pct();
        case (traffic)
            TRAFFIC_SINK_STALL: return 62;
            TRAFFIC_BOTH:       return 6;
            default:            return 0;
        endcase
    endfunction

    task automatic send_request(input request_t rq, input bit typed, input status_t fixed);
        status_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= rq.req;
        s_tdata <= {6'd0, rq.elapsed, rq.speed, rq.frame_offset, rq.clip_sel, rq.next_clip,
                    rq.looping, rq.frames_per_sec, rq.end_frame, rq.start_frame};
        do @(posedge aclk); while (!s_tready);
        predicted = animate_step(rq);
        pending_status.push_back(typed ? fixed : predicted);
    endtask

    task automatic check_status(input status_t exp, input status_t act);
        if (act.assigned_id !== exp.assigned_id) begin
            $display("%0t: assigned_id expected %0d got %0d", $time, exp.assigned_id,
                     act.assigned_id);
            fails++;
        end
        if (act.table_full !== exp.table_full) begin
            $display("%0t: table_full expected %b got %b", $time, exp.table_full,
                     act.table_full);
            fails++;
        end
        if (act.clip_active !== exp.clip_active) begin
            $display("%0t: clip_active expected %b got %b", $time, exp.clip_active,
                     act.clip_active);
            fails++;
        end
        if (act.current_clip !== exp.current_clip) begin
            $display("%0t: current_clip expected %0d got %0d", $time, exp.current_clip,
                     act.current_clip);
            fails++;
        end
        if (act.frame_pos !== exp.frame_pos) begin
            $display("%0t: frame_pos expected %h got %h", $time, exp.frame_pos,
                     act.frame_pos);
            fails++;
        end
        if (act.clip_done !== exp.clip_done) begin
            $display("%0t: clip_done expected %b got %b", $time, exp.clip_done,
                     act.clip_done);
            fails++;
        end
    endtask

    // result side: stall pattern
    initial begin
        forever begin
            @(posedge aclk);
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct());
        end
    end

    // result side: compare each transfer against the oldest prediction
    initial begin
        status_t got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tdata[3:0], m_tdata[4], m_tdata[5], m_tdata[9:6],
                        m_tdata[41:10], m_tdata[42]};
                if (pending_status.size() == 0) begin
                    $display("%0t: unexpected result expected none got %h", $time, m_tdata);
                    fails++;
                end else begin
                    check_status(pending_status.pop_front(), got);
                end
            end
        end
    end

    initial begin
        status_t zero_st;
        zero_st = st_of(4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0);
        // idle block: tick, absent play, speed
        script[0]  = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b1, zero_st};
        script[1]  = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 0, 5, 'h2000, 0),
                       1'b1, zero_st};
        script[2]  = '{rq_of(sas_pkg::REQ_SPEED, 0, 0, 0, 0, 0, 0, 0, 'hFFFF, 0),
                       1'b1, zero_st};
        // clip table
        script[3]  = '{rq_of(sas_pkg::REQ_ADD, 'h0000, 'hFFFF, 'hFFFF, 1, NO_NEXT,
                             0, 0, 0, 0),
                       1'b1, st_of(4'd0, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0)};
        script[4]  = '{rq_of(sas_pkg::REQ_ADD, 'hFFFF, 'hFFFF, 'hFFFF, 0, NO_NEXT,
                             0, 0, 0, 0),
                       1'b1, st_of(4'd1, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0)};
        script[5]  = '{rq_of(sas_pkg::REQ_ADD, 100, 50, 'h1E00, 1, -16, 0, 0, 0, 0),
                       1'b1, st_of(4'd2, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0)};
        script[6]  = '{rq_of(sas_pkg::REQ_ADD, 7, 9, 'h3C00, 0, 2, 0, 0, 0, 0),
                       1'b1, st_of(4'd3, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0)};
        script[7]  = '{rq_of(sas_pkg::REQ_ADD, 0, 0, 'h0100, 0, 15, 0, 0, 0, 0),
                       1'b1, st_of(4'd4, 1'b0, 1'b0, 4'd0, 32'd0, 1'b0)};
        // saturation at the top frame
        script[8]  = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 1, 'hFFFF, 'hFFFF, 0),
                       1'b1, st_of(4'd0, 1'b0, 1'b1, 4'd1, 32'hFFFF_0000, 1'b0)};
        script[9]  = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b1, st_of(4'd0, 1'b0, 1'b1, 4'd1, 32'hFFFF_FFFF, 1'b1)};
        script[10] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b1, st_of(4'd0, 1'b0, 1'b1, 4'd1, 32'hFFFF_FFFF, 1'b1)};
        // full-range loop, zero speed then max speed
        script[11] = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 0, 'hFFFF, 'h0000, 0),
                       1'b0, zero_st};
        script[12] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b0, zero_st};
        script[13] = '{rq_of(sas_pkg::REQ_SPEED, 0, 0, 0, 0, 0, 0, 0, 'hFFFF, 0),
                       1'b0, zero_st};
        script[14] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b0, zero_st};
        // end below start
        script[15] = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 2, 1234, 'h1000, 0),
                       1'b0, zero_st};
        script[16] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b0, zero_st};
        // chain into clip 2
        script[17] = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 3, 5, 'h1000, 0),
                       1'b0, zero_st};
        script[18] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'h8000),
                       1'b0, zero_st};
        // one-frame clip chaining to an absent clip
        script[19] = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 4, 3, 'h2000, 0),
                       1'b0, zero_st};
        script[20] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'hFFFF),
                       1'b0, zero_st};
        script[21] = '{rq_of(sas_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 'h1234),
                       1'b0, zero_st};
        script[22] = '{rq_of(sas_pkg::REQ_PLAY, 0, 0, 0, 0, 0, 15, 9, 'h0800, 0),
                       1'b0, zero_st};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < SCRIPT_LEN; k++)
            send_request(script[k].rq, script[k].typed, script[k].st);

        for (int p = TRAFFIC_FREE; p <= TRAFFIC_BOTH; p++) begin
            traffic = traffic_t'(p);
            repeat (ITEMS_PER_PHASE)
                send_request(random_request(), 1'b0, zero_st);
        end
        s_tvalid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
